// ===== hdl/dscs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drive state change sequencer package
// Shared types, command and register codes, and the transition table.
// ----------------------------------------------------------------------------
package dscs_pkg;

  localparam int unsigned STATE_W = 3;
  localparam int unsigned TRANS_W = 4;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned TIMER_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
  localparam logic [COUNT_W-1:0] MIN_SUCCESS_RESET = 8'd1;
  localparam logic [TIMER_W-1:0] MIN_WAIT_RESET    = 16'd0;

  typedef enum logic [1:0] {
    CMD_REQUEST = 2'd0,
    CMD_READING = 2'd1,
    CMD_TICK    = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_SUCCESS = 2'd0,
    REG_MIN_WAIT    = 2'd1
  } reg_idx_t;

  typedef enum logic [STATE_W-1:0] {
    DS_NOTREADY   = 3'd0,
    DS_DISABLED   = 3'd1,
    DS_READY      = 3'd2,
    DS_ON         = 3'd3,
    DS_ENABLED    = 3'd4,
    DS_QUICKSTOP  = 3'd5,
    DS_FAULTREACT = 3'd6,
    DS_FAULT      = 3'd7
  } drive_state_t;

  typedef struct packed {
    logic [STATE_W-1:0] goal;
    logic               armed;
    logic               success;
    logic [COUNT_W-1:0] match_count;
    logic [TIMER_W-1:0] wait_timer;
    logic [TRANS_W-1:0] held_trans;
  } seq_state_t;

  typedef struct packed {
    logic [TRANS_W-1:0] transition;
    logic               busy;
    logic               reached;
    logic               bad;
  } seq_result_t;

  // Next transition for a (target, current) pair; zero means none.
  function automatic logic [TRANS_W-1:0] next_transition(
    input logic [STATE_W-1:0] tgt,
    input logic [STATE_W-1:0] cur
  );
    logic [TRANS_W-1:0] tr;
    tr = 4'd0;
    if (cur == DS_FAULT) begin
      if (tgt != DS_NOTREADY && tgt != DS_FAULTREACT && tgt != DS_FAULT) begin
        tr = 4'd15;
      end
    end else if (cur == DS_QUICKSTOP) begin
      if (tgt != DS_NOTREADY && tgt != DS_FAULTREACT && tgt != DS_FAULT
          && tgt != DS_QUICKSTOP) begin
        tr = 4'd12;
      end
    end else begin
      case (tgt)
        DS_DISABLED: begin
          case (cur)
            DS_READY:   tr = 4'd7;
            DS_ON:      tr = 4'd10;
            DS_ENABLED: tr = 4'd9;
            default:    tr = 4'd0;
          endcase
        end
        DS_READY: begin
          case (cur)
            DS_DISABLED: tr = 4'd2;
            DS_ON:       tr = 4'd6;
            DS_ENABLED:  tr = 4'd8;
            default:     tr = 4'd0;
          endcase
        end
        DS_ON: begin
          case (cur)
            DS_DISABLED: tr = 4'd2;
            DS_READY:    tr = 4'd3;
            DS_ENABLED:  tr = 4'd5;
            default:     tr = 4'd0;
          endcase
        end
        DS_ENABLED: begin
          case (cur)
            DS_DISABLED: tr = 4'd2;
            DS_READY:    tr = 4'd3;
            DS_ON:       tr = 4'd4;
            default:     tr = 4'd0;
          endcase
        end
        DS_QUICKSTOP: begin
          case (cur)
            DS_DISABLED: tr = 4'd2;
            DS_READY:    tr = 4'd3;
            DS_ON:       tr = 4'd4;
            DS_ENABLED:  tr = 4'd11;
            default:     tr = 4'd0;
          endcase
        end
        default: tr = 4'd0;
      endcase
    end
    return tr;
  endfunction

endpackage

// ===== hdl/dscs_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequencer step logic
// Next state and result word for one accepted input word.
// ----------------------------------------------------------------------------
module dscs_step (
  input  dscs_pkg::seq_state_t              state_i,
  input  logic [1:0]                        cmd_i,
  input  logic [dscs_pkg::STATE_W-1:0]      target_i,
  input  logic [dscs_pkg::STATE_W-1:0]      current_i,
  input  logic [dscs_pkg::COUNT_W-1:0]      min_success_i,
  input  logic [dscs_pkg::TIMER_W-1:0]      min_wait_i,
  output dscs_pkg::seq_state_t              state_o,
  output dscs_pkg::seq_result_t             result_o
);

  logic [dscs_pkg::COUNT_W-1:0] count_inc;
  logic                         bad;

  always_comb begin
    state_o   = state_i;
    bad       = 1'b0;
    count_inc = (state_i.match_count != dscs_pkg::COUNT_MAX)
                ? state_i.match_count + 8'd1 : state_i.match_count;
    case (cmd_i)
      dscs_pkg::CMD_REQUEST: begin
        state_o.goal       = target_i;
        state_o.armed      = 1'b1;
        state_o.success    = 1'b0;
        state_o.wait_timer = '0;
      end
      dscs_pkg::CMD_TICK: begin
        if (state_i.wait_timer != dscs_pkg::TIMER_MAX) begin
          state_o.wait_timer = state_i.wait_timer + 16'd1;
        end
      end
      dscs_pkg::CMD_READING: begin
        if (state_i.armed) begin
          if (current_i == state_i.goal) begin
            state_o.match_count = count_inc;
            // compare against the count after this reading
            if (count_inc >= min_success_i) begin
              state_o.armed       = 1'b0;
              state_o.match_count = '0;
              state_o.success     = 1'b1;
            end
          end else if (state_i.wait_timer > min_wait_i) begin
            state_o.held_trans = dscs_pkg::next_transition(state_i.goal, current_i);
            bad                = (state_o.held_trans == '0);
            state_o.wait_timer = '0;
          end
        end
      end
      default: ;  // unused command: hold everything
    endcase
  end

  assign result_o.transition = state_o.held_trans;
  assign result_o.busy       = state_o.armed;
  assign result_o.reached    = state_o.success;
  assign result_o.bad        = bad;

endmodule

// ===== hdl/dscs_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result output buffer
// Output register with a skid stage so input stays open through a one-word stall.
// ----------------------------------------------------------------------------
module dscs_out_buf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push_i,
  input  dscs_pkg::seq_result_t  data_i,
  output logic                   space_o,
  output logic                   valid_o,
  input  logic                   ready_i,
  output dscs_pkg::seq_result_t  data_o
);

  logic                  out_valid_r;
  logic                  skid_valid_r;
  dscs_pkg::seq_result_t out_data_r;
  dscs_pkg::seq_result_t skid_data_r;
  logic                  can_load;

  assign can_load = !out_valid_r || ready_i;
  assign space_o  = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (can_load) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= push_i;
      end
    end else if (push_i) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load) begin
      out_data_r <= skid_valid_r ? skid_data_r : data_i;
    end else if (push_i) begin
      // park the word while the output is stalled
      skid_data_r <= data_i;
    end
  end

  assign valid_o = out_valid_r;
  assign data_o  = out_data_r;

endmodule

// ===== hdl/drive_state_change_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drive state change sequencer
// Steers a drive toward a requested state, one transition code at a time.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    cmd, target_state, current_state
//   out_     output     out_valid / out_ready  transition, busy_res, reached,
//                                              bad_transition
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_wdata
//
// One word in per cycle while in_ready is high; its result word is valid the
// cycle after acceptance when the output register is free, otherwise once the
// word ahead has left.
// An output register plus a skid stage keep in_ready high through a one-word
// output stall; in_ready drops only while the skid stage is occupied.
// Synchronous active-low reset; cfg_ready is always high.
// ----------------------------------------------------------------------------
module drive_state_change_sequencer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_cmd,
  input  logic [dscs_pkg::STATE_W-1:0]        in_target_state,
  input  logic [dscs_pkg::STATE_W-1:0]        in_current_state,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dscs_pkg::TRANS_W-1:0]        out_transition,
  output logic                                out_busy_res,
  output logic                                out_reached,
  output logic                                out_bad_transition,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dscs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dscs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  dscs_pkg::seq_state_t         state_r;
  dscs_pkg::seq_state_t         state_nxt;
  dscs_pkg::seq_result_t        result;
  dscs_pkg::seq_result_t        out_data;
  logic [dscs_pkg::COUNT_W-1:0] min_success_r;
  logic [dscs_pkg::TIMER_W-1:0] min_wait_r;
  logic                         accept;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_success_r <= dscs_pkg::MIN_SUCCESS_RESET;
      min_wait_r    <= dscs_pkg::MIN_WAIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dscs_pkg::REG_MIN_SUCCESS: min_success_r <= cfg_wdata[dscs_pkg::COUNT_W-1:0];
        dscs_pkg::REG_MIN_WAIT:    min_wait_r    <= cfg_wdata;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  dscs_step u_step (
    .state_i       (state_r),
    .cmd_i         (in_cmd),
    .target_i      (in_target_state),
    .current_i     (in_current_state),
    .min_success_i (min_success_r),
    .min_wait_i    (min_wait_r),
    .state_o       (state_nxt),
    .result_o      (result)
  );

  dscs_out_buf u_out_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (accept),
    .data_i  (result),
    .space_o (in_ready),
    .valid_o (out_valid),
    .ready_i (out_ready),
    .data_o  (out_data)
  );

  assign out_transition     = out_data.transition;
  assign out_busy_res       = out_data.busy;
  assign out_reached        = out_data.reached;
  assign out_bad_transition = out_data.bad;

endmodule

// ===== hdl/dscs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequencer port checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module dscs_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [dscs_pkg::TRANS_W-1:0] out_transition,
  input logic                         out_busy_res,
  input logic                         out_reached,
  input logic                         out_bad_transition
);

  // a stalled word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // a missing transition always shows as all bits clear
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_transition |-> out_transition == '0)
    else $error("bad transition with non-zero code");

  // done and armed never show together
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_reached && out_busy_res))
    else $error("reached while still busy");

  // a lookup only happens while armed, and it leaves the sequencer armed
  a_bad_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_transition |-> out_busy_res)
    else $error("bad transition while not busy");

endmodule

bind drive_state_change_sequencer dscs_checker u_dscs_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_transition     (out_transition),
  .out_busy_res       (out_busy_res),
  .out_reached        (out_reached),
  .out_bad_transition (out_bad_transition)
);
